// ----- hdl/cdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int ACT_W  = 3;

    localparam int S_DATA_W = ((ACT_W + DATA_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((1 + DATA_W + CNT_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SERVE  = 3'd4;

    // zero acts as one, anything above the ring size acts as the ring size
    function automatic logic [CNT_W-1:0] cap_eff(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] c;
        if (cap == '0) begin
            c = CNT_W'(1);
        end else if (32'(cap) > DEPTH) begin
            c = CNT_W'(DEPTH);
        end else begin
            c = CNT_W'(cap);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/circular_deque_with_front_decrement.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ring-buffer deque of 16-bit values over a 16-entry single-port-write memory with a
// registered read. The front entry is read at item accept and comes back the next cycle;
// the result is loaded into the output register once that is free (a serve then writes
// the decremented entry back), and only then is the next item taken. The output register
// lets one further item be taken while a result waits; that item then holds until the
// output is free. A capacity write empties the deque at once and keeps the stored values.
module circular_deque_with_front_decrement
    import cdq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CAP_W-1:0]    i_cfg_wdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,   // action, item_value
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [M_DATA_W-1:0]      m_axis_tdata    // ok, item_out, entries
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state              r_state;
    logic [CAP_W-1:0]    r_cap;
    logic [ADDR_W-1:0]   r_head;
    logic [ADDR_W-1:0]   r_tail;
    logic [CNT_W-1:0]    r_occ;
    logic                r_ok;
    logic                r_ret;
    logic                r_serve;
    logic [ADDR_W-1:0]   r_addr;
    logic [CNT_W-1:0]    r_entries;
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic [DATA_W-1:0]   r_rdata;

    logic [DATA_W-1:0]   mem [DEPTH];

    logic [ACT_W-1:0]    act;
    logic [DATA_W-1:0]   val;
    logic [CNT_W-1:0]    cap;
    logic                full;
    logic                empty;
    logic                s_acc;
    logic                out_free;
    logic [ADDR_W-1:0]   head_inc;
    logic [ADDR_W-1:0]   tail_inc;
    logic [ADDR_W-1:0]   head_dec;
    logic [ADDR_W-1:0]   n_head;
    logic [ADDR_W-1:0]   n_tail;
    logic [CNT_W-1:0]    n_occ;
    logic                n_ok;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic [DATA_W-1:0]   item;

    assign act   = s_axis_tdata[ACT_W-1:0];
    assign val   = s_axis_tdata[ACT_W +: DATA_W];
    assign cap   = cap_eff(r_cap);
    assign full  = r_occ >= cap;
    assign empty = r_occ == '0;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign head_inc = ((CNT_W'(r_head) + CNT_W'(1)) >= cap) ? '0 : r_head + ADDR_W'(1);
    assign tail_inc = ((CNT_W'(r_tail) + CNT_W'(1)) >= cap) ? '0 : r_tail + ADDR_W'(1);
    assign head_dec = (r_head == '0 || CNT_W'(r_head) >= cap)
                    ? ADDR_W'(cap - CNT_W'(1)) : r_head - ADDR_W'(1);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        n_ok   = 1'b0;
        unique case (act) inside
            ACT_APPEND: begin
                if (!full) begin
                    n_tail = tail_inc;
                    n_occ  = r_occ + CNT_W'(1);
                    n_ok   = 1'b1;
                end
            end
            ACT_PUSH: begin
                if (!full) begin
                    n_head = head_dec;
                    n_occ  = r_occ + CNT_W'(1);
                    n_ok   = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (!empty) begin
                    n_head = head_inc;
                    n_occ  = r_occ - CNT_W'(1);
                    n_ok   = 1'b1;
                end
            end
            ACT_PEEK, ACT_SERVE: begin
                n_ok = !empty;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // one write port: stores at item accept, serve write-back in the read cycle
    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = r_rdata - DATA_W'(1);
        if (r_state == ST_READ) begin
            we = r_serve && out_free;
        end else if (s_acc && !full && (act == ACT_APPEND || act == ACT_PUSH)) begin
            we    = 1'b1;
            waddr = (act == ACT_APPEND) ? tail_inc : head_dec;
            wdata = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (s_acc) begin
            r_rdata <= mem[r_head];
        end
    end

    assign item = r_ret ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cap     <= CAP_RESET;
            r_head    <= '0;
            r_tail    <= ADDR_W'(cap_eff(CAP_RESET) - CNT_W'(1));
            r_occ     <= '0;
            r_m_valid <= 1'b0;
            r_m_data  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap  <= i_cfg_wdata;
                r_head <= '0;
                r_tail <= ADDR_W'(cap_eff(i_cfg_wdata) - CNT_W'(1));
                r_occ  <= '0;
            end else if (s_acc) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_occ  <= n_occ;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                    if (s_acc) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= M_DATA_W'({r_entries, item, r_ok});
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ok      <= n_ok;
            r_ret     <= n_ok && (act == ACT_REMOVE || act == ACT_PEEK);
            r_serve   <= n_ok && (act == ACT_SERVE);
            r_addr    <= r_head;
            r_entries <= n_occ;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_occ_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= cap)
        else $error("occupancy above capacity");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_head) < cap && CNT_W'(r_tail) < cap)
        else $error("pointer outside ring");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("item taken while previous one in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_data[0]) |-> (r_m_data[DATA_W:1] == '0))
        else $error("failed item returns nonzero data");

endmodule

`default_nettype wire
